// ----- design/base64_line_encoder_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the base64 line encoder.
// ----------------------------------------------------------------------------
`ifndef BASE64_LINE_ENCODER_TOP_MACROS_SVH
`define BASE64_LINE_ENCODER_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define B64LE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("base64 line encoder assertion failed");

// Property checked on every clock edge, reset included.
`define B64LE_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("base64 line encoder assertion failed");

`endif

// ----- design/b64le_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_pkg
// Shared types, constants and the symbol function of the base64 line encoder.
// ----------------------------------------------------------------------------
package b64le_pkg;

   localparam logic [7:0] CHAR_CR        = 8'd13;
   localparam logic [7:0] CHAR_PAD       = 8'd61;
   localparam logic [7:0] LINE_WIDTH_RST = 8'd76;

   localparam int SLOT_COUNT = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Positions in the slot mask of a command.
   localparam logic [2:0] SLOT_SYM0     = 3'd0;
   localparam logic [2:0] SLOT_SYM1     = 3'd1;
   localparam logic [2:0] SLOT_SYM2     = 3'd2;
   localparam logic [2:0] SLOT_SYM3     = 3'd3;
   localparam logic [2:0] SLOT_GROUP_CR = 3'd4;
   localparam logic [2:0] SLOT_OPEN_CR  = 3'd5;
   localparam logic [2:0] SLOT_TERM_CR  = 3'd6;

   typedef struct packed {
      logic [23:0]           group_bits;
      logic [1:0]            pad;
      logic [SLOT_COUNT-1:0] slots;
   } cmd_type;

   function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
      logic [7:0] sym;
      priority if (idx < 6'd26) begin
         sym = 8'd65 + {2'b00, idx};
      end else if (idx < 6'd52) begin
         sym = 8'd71 + {2'b00, idx};
      end else if (idx < 6'd62) begin
         sym = {2'b00, idx} - 8'd4;
      end else if (idx == 6'd62) begin
         sym = 8'd43;
      end else begin
         sym = 8'd47;
      end
      return sym;
   endfunction

endpackage

// ----- design/b64le_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_front
// Gathers bytes into groups, tracks the line position and turns each request
// into a command that lists the characters it causes.
// ----------------------------------------------------------------------------
module b64le_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               byte_valid,
   input  logic               end_of_stream,
   output logic               cmd_push,
   output b64le_pkg::cmd_type cmd
);

   localparam int SLOT_SYM3_IDX = int'(b64le_pkg::SLOT_SYM3);

   logic [7:0]  line_width_ff, line_width_in;
   logic [15:0] bytes_ff, bytes_in;
   logic [1:0]  count_ff, count_in;
   logic [7:0]  pos_ff, pos_in;
   logic [8:0]  pos_next;

   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      cmd      = '0;
      pos_next = {1'b0, pos_ff} + 9'd4;
      if (byte_valid) begin
         unique case (count_ff)
            2'd0: begin
               bytes_in = {data_byte, 8'h00};
               count_in = 2'd1;
            end
            2'd1: begin
               bytes_in = {bytes_ff[15:8], data_byte};
               count_in = 2'd2;
            end
            default: begin
               cmd.group_bits = {bytes_ff, data_byte};
               cmd.slots[SLOT_SYM3_IDX:0] = '1;
               bytes_in = '0;
               count_in = 2'd0;
               if ((pos_next >= {1'b0, line_width_ff}) || end_of_stream) begin
                  cmd.slots[b64le_pkg::SLOT_GROUP_CR] = 1'b1;
                  pos_in = '0;
               end else begin
                  pos_in = pos_next[7:0];
               end
            end
         endcase
      end
      if (end_of_stream) begin
         if (count_in == 2'd1) begin
            cmd.group_bits = {bytes_in[15:8], 16'h0000};
            cmd.pad = 2'd2;
            cmd.slots[SLOT_SYM3_IDX:0] = '1;
            cmd.slots[b64le_pkg::SLOT_GROUP_CR] = 1'b1;
         end else if (count_in == 2'd2) begin
            cmd.group_bits = {bytes_in, 8'h00};
            cmd.pad = 2'd1;
            cmd.slots[SLOT_SYM3_IDX:0] = '1;
            cmd.slots[b64le_pkg::SLOT_GROUP_CR] = 1'b1;
         end else if (pos_in != 8'd0) begin
            cmd.slots[b64le_pkg::SLOT_OPEN_CR] = 1'b1;
         end
         cmd.slots[b64le_pkg::SLOT_TERM_CR] = 1'b1;
         bytes_in = '0;
         count_in = 2'd0;
         pos_in   = '0;
      end
   end

   assign cmd_push      = accept && (|cmd.slots);
   assign line_width_in = csr_wr_en ? csr_wr_data : line_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= b64le_pkg::LINE_WIDTH_RST;
         bytes_ff      <= '0;
         count_ff      <= '0;
         pos_ff        <= '0;
      end else begin
         line_width_ff <= line_width_in;
         if (accept) begin
            bytes_ff <= bytes_in;
            count_ff <= count_in;
            pos_ff   <= pos_in;
         end
      end
   end

endmodule

// ----- design/b64le_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module b64le_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  b64le_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output b64le_pkg::cmd_type head_cmd,
   output logic               empty
);

   localparam int PTR_W = b64le_pkg::QUEUE_PTR_W;

   b64le_pkg::cmd_type entries_ff [b64le_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == (PTR_W + 1)'(b64le_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(b64le_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(b64le_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- design/b64le_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_back
// Walks the slots of one command into the output register, one character per
// cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module b64le_back (
   input  logic               clock,
   input  logic               reset,
   input  b64le_pkg::cmd_type head_cmd,
   input  logic               q_empty,
   output logic               q_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [7:0]         rsp_out_char,
   output logic               rsp_run_last
);

   localparam int NS = b64le_pkg::SLOT_COUNT;

   b64le_pkg::cmd_type cmd_ff, cmd_in;
   logic [NS-1:0] rem_ff, rem_in, rem_left, rem_after, low_bit;
   logic [2:0]    sel;
   logic          advance, load, taken;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_char_ff, out_char_in;
   logic          out_last_ff, out_last_in;

   always_comb begin
      sel = '0;
      for (int i = NS - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            sel = 3'(i);
         end
      end
      low_bit = NS'(1) << sel;
   end

   always_comb begin
      unique case (sel)
         b64le_pkg::SLOT_SYM0: out_char_in = b64le_pkg::b64_symbol(cmd_ff.group_bits[23:18]);
         b64le_pkg::SLOT_SYM1: out_char_in = b64le_pkg::b64_symbol(cmd_ff.group_bits[17:12]);
         b64le_pkg::SLOT_SYM2: out_char_in = cmd_ff.pad[1] ? b64le_pkg::CHAR_PAD :
                                             b64le_pkg::b64_symbol(cmd_ff.group_bits[11:6]);
         b64le_pkg::SLOT_SYM3: out_char_in = (|cmd_ff.pad) ? b64le_pkg::CHAR_PAD :
                                             b64le_pkg::b64_symbol(cmd_ff.group_bits[5:0]);
         default:              out_char_in = b64le_pkg::CHAR_CR;
      endcase
   end

   assign taken        = rsp_pop && out_valid_ff;
   assign advance      = (|rem_ff) && (!out_valid_ff || rsp_pop);
   assign rem_left     = rem_ff & ~low_bit;
   assign rem_after    = advance ? rem_left : rem_ff;
   assign load         = (rem_after == '0) && !q_empty;
   assign q_pop        = load;
   assign rem_in       = load ? head_cmd.slots : rem_after;
   assign cmd_in       = load ? head_cmd : cmd_ff;
   assign out_last_in  = (rem_left == '0);
   assign out_valid_in = advance || (out_valid_ff && !taken);

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (advance) begin
         out_char_ff <= out_char_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_run_last = out_last_ff;

endmodule

// ----- design/base64_line_encoder_top.sv -----
`timescale 1ns / 1ps
// A request's first character passes the command queue, the command register and the output
// register before it shows on the result side. Throughput: one request per cycle is taken while
// the command queue has room; the back emits one character per cycle while rsp_pop is high.
// Reset: synchronous, active high; clears queue, group state and line position, and sets
// the line width to 76.
// ----------------------------------------------------------------------------
// base64_line_encoder_top
// Byte stream to base64 text with carriage returns at line ends.
// ----------------------------------------------------------------------------
module base64_line_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_valid,
   input  logic       req_end_of_stream,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_last
);

   b64le_pkg::cmd_type push_cmd, head_cmd;
   logic               cmd_push, q_full, q_empty, q_pop, accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   b64le_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .byte_valid    (req_byte_valid),
      .end_of_stream (req_end_of_stream),
      .cmd_push      (cmd_push),
      .cmd           (push_cmd)
   );

   b64le_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   b64le_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_char (rsp_out_char),
      .rsp_run_last (rsp_run_last)
   );

endmodule

// ----- design/b64le_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_checker
// Port-level checks of the base64 line encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "base64_line_encoder_top_macros.svh"

module b64le_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_char,
   input logic       rsp_run_last
);

   // After reset nothing waits and a request can be taken.
   `B64LE_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (rsp_empty && !req_full))

   // A waiting character that is not popped stays as it is.
   `B64LE_ASSERT(a_rsp_hold, clock, reset,
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_char) && $stable(rsp_run_last)))

   // A pad character is always followed by more characters of the same request.
   `B64LE_ASSERT(a_pad_not_last, clock, reset,
      (!rsp_empty && (rsp_out_char == b64le_pkg::CHAR_PAD)) |-> !rsp_run_last)

   // The last character of an end request is a carriage return; a popped pad never
   // ends the output, so a character after a pad is pad or carriage return.
   `B64LE_ASSERT(a_after_pad, clock, reset,
      (!rsp_empty && rsp_pop && (rsp_out_char == b64le_pkg::CHAR_PAD)) |=>
      (rsp_empty || (rsp_out_char == b64le_pkg::CHAR_PAD) ||
       (rsp_out_char == b64le_pkg::CHAR_CR)))

endmodule

bind base64_line_encoder_top b64le_checker u_checker (.*);
